// ===== rtl/core/dial_override_slew_controller_defines.svh =====
// Assertion macros shared by the dial override slew controller RTL.
// Included by dosc_core, the module that carries concurrent checks; no other dependencies.
`ifndef DIAL_OVERRIDE_SLEW_CONTROLLER_DEFINES_SVH
`define DIAL_OVERRIDE_SLEW_CONTROLLER_DEFINES_SVH

// Same-cycle implication, disabled during reset
`define DOSC_ASSERT_IMP(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("dosc assertion failed");

// Next-cycle implication, disabled during reset
`define DOSC_ASSERT_NXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("dosc assertion failed");

`endif

// ===== rtl/core/dosc_pkg.sv =====
// Shared types, constants and helper functions for the dial override slew controller.
// No dependencies; imported by the interfaces and every module of the block.
`default_nettype none

package dosc_pkg;

   localparam int SAMPLE_BITS_DEF = 12;
   localparam int LEVEL_BITS      = 8;
   localparam int CSR_ADDR_BITS   = 5;
   localparam int CSR_DATA_BITS   = 32;
   localparam int REG_INDEX_BITS  = 3;

   localparam logic OP_TICK = 1'b0;
   localparam logic OP_BYTE = 1'b1;

   typedef enum logic [REG_INDEX_BITS-1:0] {
      REG_WATCHDOG_LIMIT     = 3'd0,
      REG_OFF_LEVEL          = 3'd1,
      REG_MIN_OVERRIDE_LEVEL = 3'd2,
      REG_WAKE_LEVEL         = 3'd3,
      REG_MAX_STEP           = 3'd4,
      REG_PASSTHROUGH_CODE   = 3'd5
   } reg_index_type;

   typedef struct packed {
      logic [LEVEL_BITS-1:0] watchdog_limit;
      logic [LEVEL_BITS-1:0] off_level;
      logic [LEVEL_BITS-1:0] min_override_level;
      logic [LEVEL_BITS-1:0] wake_level;
      logic [LEVEL_BITS-1:0] max_step;
      logic [LEVEL_BITS-1:0] passthrough_code;
   } dosc_cfg_type;

   localparam dosc_cfg_type CFG_RESET = '{
      watchdog_limit:     8'd200,
      off_level:          8'd5,
      min_override_level: 8'd25,
      wake_level:         8'd230,
      max_step:           8'd3,
      passthrough_code:   8'h00
   };

   function automatic logic parity8(input logic [LEVEL_BITS-1:0] v);
      return ^v;
   endfunction

   // Move cur toward target by at most step
   function automatic logic [LEVEL_BITS-1:0] slew_level(
      input logic [LEVEL_BITS-1:0] cur,
      input logic [LEVEL_BITS-1:0] target,
      input logic [LEVEL_BITS-1:0] step
   );
      logic [LEVEL_BITS-1:0] diff;
      logic [LEVEL_BITS-1:0] res;
      res = cur;
      if (target > cur) begin
         diff = target - cur;
         res  = cur + ((diff > step) ? step : diff);
      end else if (target < cur) begin
         diff = cur - target;
         res  = cur - ((diff > step) ? step : diff);
      end
      return res;
   endfunction

endpackage

`default_nettype wire

// ===== rtl/core/dosc_req_if.sv =====
// Input channel of the dial override slew controller: tick or received byte.
// Depends on dosc_pkg for the default sample width.
`default_nettype none

interface dosc_req_if #(
   parameter int SAMPLE_BITS = dosc_pkg::SAMPLE_BITS_DEF
) ();
   import dosc_pkg::*;

   logic                   valid;
   logic                   ready;
   logic                   opcode;
   logic [SAMPLE_BITS-1:0] dial_sample;
   logic [LEVEL_BITS-1:0]  rx_data;
   logic                   rx_parity;

   modport source (output valid, opcode, dial_sample, rx_data, rx_parity, input ready);
   modport sink   (input valid, opcode, dial_sample, rx_data, rx_parity, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/dosc_rsp_if.sv =====
// Result channel of the dial override slew controller: one word per tick.
// Depends on dosc_pkg for the level width.
`default_nettype none

interface dosc_rsp_if ();
   import dosc_pkg::*;

   logic                  valid;
   logic                  ready;
   logic [LEVEL_BITS-1:0] dac_level;
   logic                  drive_enable;
   logic                  send_valid;
   logic [LEVEL_BITS-1:0] send_byte;
   logic                  send_parity;

   modport source (output valid, dac_level, drive_enable, send_valid, send_byte, send_parity,
                   input ready);
   modport sink   (input valid, dac_level, drive_enable, send_valid, send_byte, send_parity,
                   output ready);
endinterface

`default_nettype wire

// ===== rtl/core/dosc_csr.sv =====
// APB-style configuration registers of the dial override slew controller.
// Depends on dosc_pkg for the register map and the configuration struct.
`default_nettype none

module dosc_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [dosc_pkg::CSR_ADDR_BITS-1:0]  paddr,
   input  logic [dosc_pkg::CSR_DATA_BITS-1:0]  pwdata,
   output logic [dosc_pkg::CSR_DATA_BITS-1:0]  prdata,
   output logic                                pready,
   output dosc_pkg::dosc_cfg_type              cfg
);
   import dosc_pkg::*;

   dosc_cfg_type          cfg_ff;
   reg_index_type         reg_idx;
   logic                  wr_en;
   logic [LEVEL_BITS-1:0] wr_val;
   logic [LEVEL_BITS-1:0] rd_val;

   assign reg_idx = reg_index_type'(paddr[CSR_ADDR_BITS-1:2]);
   assign wr_en   = psel && penable && pwrite;
   assign wr_val  = pwdata[LEVEL_BITS-1:0];
   assign pready  = 1'b1;
   assign cfg     = cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= CFG_RESET;
      end else if (wr_en) begin
         unique case (reg_idx)
            REG_WATCHDOG_LIMIT:     cfg_ff.watchdog_limit     <= wr_val;
            REG_OFF_LEVEL:          cfg_ff.off_level          <= wr_val;
            REG_MIN_OVERRIDE_LEVEL: cfg_ff.min_override_level <= wr_val;
            REG_WAKE_LEVEL:         cfg_ff.wake_level         <= wr_val;
            REG_MAX_STEP:           cfg_ff.max_step           <= wr_val;
            REG_PASSTHROUGH_CODE:   cfg_ff.passthrough_code   <= wr_val;
            default:                cfg_ff                    <= cfg_ff;
         endcase
      end
   end

   always_comb begin
      unique case (reg_idx)
         REG_WATCHDOG_LIMIT:     rd_val = cfg_ff.watchdog_limit;
         REG_OFF_LEVEL:          rd_val = cfg_ff.off_level;
         REG_MIN_OVERRIDE_LEVEL: rd_val = cfg_ff.min_override_level;
         REG_WAKE_LEVEL:         rd_val = cfg_ff.wake_level;
         REG_MAX_STEP:           rd_val = cfg_ff.max_step;
         REG_PASSTHROUGH_CODE:   rd_val = cfg_ff.passthrough_code;
         default:                rd_val = '0;
      endcase
   end

   assign prdata = {{(CSR_DATA_BITS-LEVEL_BITS){1'b0}}, rd_val};

endmodule

`default_nettype wire

// ===== rtl/core/dosc_core.sv =====
// Event datapath: input register, state update and result register.
// Depends on dosc_pkg, dosc_req_if, dosc_rsp_if and the assertion macro header.
`default_nettype none
`include "dial_override_slew_controller_defines.svh"

module dosc_core #(
   parameter int SAMPLE_BITS = dosc_pkg::SAMPLE_BITS_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  dosc_pkg::dosc_cfg_type cfg,
   dosc_req_if.sink               req_bus,
   dosc_rsp_if.source             rsp_bus
);
   import dosc_pkg::*;

   // input register
   logic                  in_valid_ff;
   logic                  in_op_ff;
   logic [LEVEL_BITS-1:0] in_sample_ff;
   logic [LEVEL_BITS-1:0] in_data_ff;
   logic                  in_par_ff;

   // block state
   logic [LEVEL_BITS-1:0] code_ff,     code_in;
   logic                  pending_ff,  pending_in;
   logic [LEVEL_BITS-1:0] watchdog_ff, watchdog_in;
   logic [LEVEL_BITS-1:0] level_ff,    level_in;

   // result register
   logic                  out_valid_ff, out_valid_in;
   logic [LEVEL_BITS-1:0] out_level_ff;
   logic                  out_enable_ff;
   logic                  out_send_ff;
   logic [LEVEL_BITS-1:0] out_byte_ff;
   logic                  out_par_ff;

   logic                  advance;
   logic                  is_tick;
   logic                  send;
   logic [LEVEL_BITS-1:0] wd_tick;
   logic [LEVEL_BITS-1:0] code_eff;
   logic [LEVEL_BITS-1:0] target;
   logic [LEVEL_BITS-1:0] level_tick;

   assign is_tick = (in_op_ff == OP_TICK);
   // a byte word leaves no result, so it never waits on the output side
   assign advance = in_valid_ff && (!is_tick || !out_valid_ff || rsp_bus.ready);
   assign req_bus.ready = !in_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_bus.ready) begin
         in_valid_ff <= req_bus.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_bus.valid && req_bus.ready) begin
         in_op_ff     <= req_bus.opcode;
         in_sample_ff <= req_bus.dial_sample[SAMPLE_BITS-1 -: LEVEL_BITS];
         in_data_ff   <= req_bus.rx_data;
         in_par_ff    <= req_bus.rx_parity;
      end
   end

   always_comb begin
      wd_tick  = (watchdog_ff < cfg.watchdog_limit) ? watchdog_ff + 8'd1 : watchdog_ff;
      send     = pending_ff || (in_sample_ff > cfg.wake_level);
      // a dial below the off level drops any override
      code_eff = (in_sample_ff < cfg.off_level) ? cfg.passthrough_code : code_ff;
      target   = (code_eff > cfg.min_override_level) ? code_eff : cfg.min_override_level;
      if (code_eff == cfg.passthrough_code) begin
         level_tick = in_sample_ff;
      end else if (wd_tick >= cfg.watchdog_limit) begin
         level_tick = cfg.off_level;
      end else begin
         level_tick = slew_level(level_ff, target, cfg.max_step);
      end

      code_in     = code_ff;
      pending_in  = pending_ff;
      watchdog_in = watchdog_ff;
      level_in    = level_ff;
      if (advance) begin
         if (is_tick) begin
            code_in     = code_eff;
            pending_in  = 1'b0;
            watchdog_in = wd_tick;
            level_in    = level_tick;
         end else begin
            code_in = in_data_ff;
            if (in_par_ff == parity8(in_data_ff)) begin
               watchdog_in = '0;
               pending_in  = 1'b1;
            end
         end
      end

      if (advance && is_tick) begin
         out_valid_in = 1'b1;
      end else if (rsp_bus.ready) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         code_ff      <= CFG_RESET.passthrough_code;
         pending_ff   <= 1'b0;
         watchdog_ff  <= '0;
         level_ff     <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         code_ff      <= code_in;
         pending_ff   <= pending_in;
         watchdog_ff  <= watchdog_in;
         level_ff     <= level_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && is_tick) begin
         out_level_ff  <= level_tick;
         out_enable_ff <= (level_tick >= cfg.off_level);
         out_send_ff   <= send;
         out_byte_ff   <= send ? in_sample_ff : '0;
         out_par_ff    <= send ? parity8(in_sample_ff) : 1'b0;
      end
   end

   assign rsp_bus.valid        = out_valid_ff;
   assign rsp_bus.dac_level    = out_level_ff;
   assign rsp_bus.drive_enable = out_enable_ff;
   assign rsp_bus.send_valid   = out_send_ff;
   assign rsp_bus.send_byte    = out_byte_ff;
   assign rsp_bus.send_parity  = out_par_ff;

   `DOSC_ASSERT_NXT(a_good_byte_arms_reply, clock, reset,
      advance && !is_tick && (in_par_ff == parity8(in_data_ff)),
      (watchdog_ff == '0) && pending_ff)
   `DOSC_ASSERT_NXT(a_tick_fills_output, clock, reset,
      advance && is_tick, out_valid_ff && !pending_ff && (level_ff == out_level_ff))
   `DOSC_ASSERT_NXT(a_stalled_input_holds, clock, reset,
      in_valid_ff && !advance, in_valid_ff && $stable(in_sample_ff))
   `DOSC_ASSERT_IMP(a_send_fields_consistent, clock, reset,
      out_valid_ff,
      (out_par_ff == ^out_byte_ff) && (out_send_ff || (out_byte_ff == '0)))

endmodule

`default_nettype wire

// ===== rtl/core/dial_override_slew_controller.sv =====
// Top level of the dial override slew controller: register port plus event datapath.
// Depends on dosc_pkg, dosc_req_if, dosc_rsp_if, dosc_csr and dosc_core.
//
//   channel   | direction | handshake               | word
//   req_bus   | in        | valid/ready             | opcode, dial_sample, rx_data, rx_parity
//   rsp_bus   | out       | valid/ready             | dac_level, drive_enable, send_*
//   APB       | in        | psel/penable, pready=1  | pwdata -> register at paddr[4:2]
//
// One word is accepted per cycle while the input register is empty or advancing; a tick
// is captured by the input register; the result register takes the update it yields.
// Byte words update state and produce no result, so they pass even while a result waits.
// A stalled result holds the update stage on ticks; the input register then holds too.
// Synchronous reset restores register defaults and state; data words are not reset.
`default_nettype none

module dial_override_slew_controller #(
   parameter int SAMPLE_BITS = dosc_pkg::SAMPLE_BITS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [dosc_pkg::CSR_ADDR_BITS-1:0]  paddr,
   input  logic [dosc_pkg::CSR_DATA_BITS-1:0]  pwdata,
   output logic [dosc_pkg::CSR_DATA_BITS-1:0]  prdata,
   output logic                                pready,
   dosc_req_if.sink                            req_bus,
   dosc_rsp_if.source                          rsp_bus
);
   import dosc_pkg::*;

   dosc_cfg_type cfg;

   dosc_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   dosc_core #(
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_core (
      .clock   (clock),
      .reset   (reset),
      .cfg     (cfg),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

endmodule

`default_nettype wire

// ===== test/dosc_level_checker.sv =====
// Watches the event and result channels and the register port of the dial override
// slew controller, predicts each tick's result word and compares it field by field.
// Depends on dosc_pkg, dosc_req_if and dosc_rsp_if.
`default_nettype none

module dosc_level_checker #(
   parameter int SAMPLE_BITS = dosc_pkg::SAMPLE_BITS_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               psel,
   input  logic                               penable,
   input  logic                               pwrite,
   input  logic [dosc_pkg::CSR_ADDR_BITS-1:0] paddr,
   input  logic [dosc_pkg::CSR_DATA_BITS-1:0] pwdata,
   input  logic                               pready,
   dosc_req_if                                req_bus,
   dosc_rsp_if                                rsp_bus,
   output int unsigned                        fail_count,
   output int unsigned                        words_due
);
   import dosc_pkg::*;

   typedef struct packed {
      logic [LEVEL_BITS-1:0] dac_level;
      logic                  drive_enable;
      logic                  send_valid;
      logic [LEVEL_BITS-1:0] send_byte;
      logic                  send_parity;
   } tick_word_type;

   dosc_cfg_type          cfg = CFG_RESET;
   logic [LEVEL_BITS-1:0] code_q = '0;
   logic [LEVEL_BITS-1:0] wdog_q = '0;
   logic [LEVEL_BITS-1:0] level_q = '0;
   logic                  pending_q = 1'b0;
   tick_word_type         due_words[$];
   int unsigned           fails = 0;

   assign fail_count = fails;

   task automatic check_field(input string name, input logic [LEVEL_BITS-1:0] want,
                              input logic [LEVEL_BITS-1:0] got);
      if (want !== got) begin
         $error("%s expected %0d got %0d", name, want, got);
         fails++;
      end
   endtask

   task automatic absorb_byte(input logic [LEVEL_BITS-1:0] data, input logic par);
      code_q = data;
      if (par == ^data) begin
         wdog_q    = '0;
         pending_q = 1'b1;
      end
   endtask

   task automatic predict_tick(input logic [SAMPLE_BITS-1:0] raw);
      logic [LEVEL_BITS-1:0] scaled;
      logic [LEVEL_BITS-1:0] target;
      logic [LEVEL_BITS-1:0] gap;
      tick_word_type         w;
      // hold the watchdog once it sits at or above the limit
      if (wdog_q < cfg.watchdog_limit) wdog_q = wdog_q + 8'd1;
      scaled = raw[SAMPLE_BITS-1 -: LEVEL_BITS];
      w = '0;
      if (pending_q || scaled > cfg.wake_level) begin
         w.send_valid  = 1'b1;
         w.send_byte   = scaled;
         w.send_parity = ^scaled;
      end
      pending_q = 1'b0;
      if (scaled < cfg.off_level) code_q = cfg.passthrough_code;
      if (code_q == cfg.passthrough_code) begin
         level_q = scaled;
      end else if (wdog_q >= cfg.watchdog_limit) begin
         level_q = cfg.off_level;
      end else begin
         target = (code_q > cfg.min_override_level) ? code_q : cfg.min_override_level;
         if (target > level_q) begin
            gap     = target - level_q;
            level_q = level_q + ((gap > cfg.max_step) ? cfg.max_step : gap);
         end else if (target < level_q) begin
            gap     = level_q - target;
            level_q = level_q - ((gap > cfg.max_step) ? cfg.max_step : gap);
         end
      end
      w.dac_level    = level_q;
      w.drive_enable = (level_q >= cfg.off_level);
      due_words.push_back(w);
   endtask

   task automatic write_reg(input logic [REG_INDEX_BITS-1:0] idx,
                            input logic [LEVEL_BITS-1:0] v);
      case (reg_index_type'(idx))
         REG_WATCHDOG_LIMIT:     cfg.watchdog_limit     = v;
         REG_OFF_LEVEL:          cfg.off_level          = v;
         REG_MIN_OVERRIDE_LEVEL: cfg.min_override_level = v;
         REG_WAKE_LEVEL:         cfg.wake_level         = v;
         REG_MAX_STEP:           cfg.max_step           = v;
         REG_PASSTHROUGH_CODE:   cfg.passthrough_code   = v;
         default: ;
      endcase
   endtask

   always @(posedge clock) begin
      tick_word_type exp_w;
      if (reset) begin
         cfg       = CFG_RESET;
         code_q    = '0;
         wdog_q    = '0;
         level_q   = '0;
         pending_q = 1'b0;
         due_words.delete();
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (due_words.size() == 0) begin
               $error("result word with no tick waiting for it");
               fails++;
            end else begin
               exp_w = due_words.pop_front();
               check_field("dac_level", exp_w.dac_level, rsp_bus.dac_level);
               check_field("drive_enable", LEVEL_BITS'(exp_w.drive_enable),
                           LEVEL_BITS'(rsp_bus.drive_enable));
               check_field("send_valid", LEVEL_BITS'(exp_w.send_valid),
                           LEVEL_BITS'(rsp_bus.send_valid));
               check_field("send_byte", exp_w.send_byte, rsp_bus.send_byte);
               check_field("send_parity", LEVEL_BITS'(exp_w.send_parity),
                           LEVEL_BITS'(rsp_bus.send_parity));
            end
         end
         if (req_bus.valid && req_bus.ready) begin
            if (req_bus.opcode == OP_BYTE) absorb_byte(req_bus.rx_data, req_bus.rx_parity);
            else predict_tick(req_bus.dial_sample);
         end
         if (psel && penable && pwrite && pready)
            write_reg(paddr[CSR_ADDR_BITS-1:2], pwdata[LEVEL_BITS-1:0]);
      end
      words_due = due_words.size();
   end

endmodule

`default_nettype wire

// ===== test/tb_top.sv =====
// Top of the dial override slew controller testbench: clock, reset, register phases,
// event stimulus with random gaps and result back-pressure, and the final verdict.
// Depends on dosc_pkg, the channel interfaces, the block and dosc_level_checker.
`default_nettype none

module tb_top;
   import dosc_pkg::*;

   localparam int SAMPLE_BITS     = SAMPLE_BITS_DEF;
   localparam int PHASES          = 12;
   localparam int PHASE_WORDS     = 100;
   localparam int RSP_HOLD_CYCLES = 64;
   localparam int SETTLE_CYCLES   = 8;
   localparam int LIMIT_TIME      = 400000;

   logic                     clock;
   logic                     reset;
   logic                     psel;
   logic                     penable;
   logic                     pwrite;
   logic [CSR_ADDR_BITS-1:0] paddr;
   logic [CSR_DATA_BITS-1:0] pwdata;
   logic [CSR_DATA_BITS-1:0] prdata;
   logic                     pready;
   int unsigned              fail_count;
   int unsigned              words_due;

   bit src_calm      = 1'b0;
   bit rsp_calm      = 1'b0;
   bit rsp_stall_req = 1'b0;

   dosc_req_if #(.SAMPLE_BITS(SAMPLE_BITS)) req_bus ();
   dosc_rsp_if                              rsp_bus ();

   dial_override_slew_controller #(.SAMPLE_BITS(SAMPLE_BITS)) dut (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   dosc_level_checker #(.SAMPLE_BITS(SAMPLE_BITS)) checker_i (
      .clock      (clock),
      .reset      (reset),
      .psel       (psel),
      .penable    (penable),
      .pwrite     (pwrite),
      .paddr      (paddr),
      .pwdata     (pwdata),
      .pready     (pready),
      .req_bus    (req_bus),
      .rsp_bus    (rsp_bus),
      .fail_count (fail_count),
      .words_due  (words_due)
   );

   initial clock = 1'b0;
   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   initial begin
      #(LIMIT_TIME);
      $display("tb_top NOT OK");
      $finish;
   end

   // Result side: draw a wait per word, with an occasional long hold on request
   initial begin : rsp_drain
      int gap;
      rsp_bus.ready = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         gap = rsp_calm ? 0 : $urandom_range(0, 3);
         if (rsp_stall_req) begin
            gap           = RSP_HOLD_CYCLES;
            rsp_stall_req = 1'b0;
         end
         if (gap > 0) begin
            rsp_bus.ready <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         rsp_bus.ready <= 1'b1;
         @(posedge clock);
         while (!(rsp_bus.valid && rsp_bus.ready)) @(posedge clock);
         @(negedge clock);
      end
   end

   task automatic send_word(input logic op, input logic [SAMPLE_BITS-1:0] smp,
                            input logic [LEVEL_BITS-1:0] data, input logic par);
      int gap;
      gap = src_calm ? 0 : $urandom_range(0, 3);
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_bus.valid       <= 1'b1;
      req_bus.opcode      <= op;
      req_bus.dial_sample <= smp;
      req_bus.rx_data     <= data;
      req_bus.rx_parity   <= par;
      @(posedge clock);
      while (!(req_bus.valid && req_bus.ready)) @(posedge clock);
      @(negedge clock);
   endtask

   // Drop valid and wait for every pending result, then settle
   task automatic drain(input int extra);
      req_bus.valid <= 1'b0;
      do @(negedge clock); while (words_due != 0);
      repeat (extra) @(negedge clock);
   endtask

   task automatic csr_program(input dosc_cfg_type c);
      logic [LEVEL_BITS-1:0] v;
      reg_index_type         idx;
      for (int r = 0; r <= int'(REG_PASSTHROUGH_CODE); r++) begin
         idx = reg_index_type'(r);
         case (idx)
            REG_WATCHDOG_LIMIT:     v = c.watchdog_limit;
            REG_OFF_LEVEL:          v = c.off_level;
            REG_MIN_OVERRIDE_LEVEL: v = c.min_override_level;
            REG_WAKE_LEVEL:         v = c.wake_level;
            REG_MAX_STEP:           v = c.max_step;
            default:                v = c.passthrough_code;
         endcase
         psel    <= 1'b1;
         penable <= 1'b0;
         pwrite  <= 1'b1;
         paddr   <= {idx, 2'b00};
         pwdata  <= {{(CSR_DATA_BITS-LEVEL_BITS){1'b0}}, v};
         @(negedge clock);
         penable <= 1'b1;
         @(posedge clock);
         while (!pready) @(posedge clock);
         @(negedge clock);
      end
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
   endtask

   function automatic dosc_cfg_type plan_for(input int p);
      dosc_cfg_type c;
      c.watchdog_limit     = LEVEL_BITS'($urandom_range(1, 40));
      c.off_level          = LEVEL_BITS'($urandom_range(0, 64));
      c.min_override_level = LEVEL_BITS'($urandom_range(0, 255));
      c.wake_level         = LEVEL_BITS'($urandom_range(128, 255));
      c.max_step           = LEVEL_BITS'($urandom_range(0, 1) ? $urandom_range(1, 16)
                                                              : $urandom_range(1, 255));
      c.passthrough_code   = LEVEL_BITS'(($urandom_range(0, 3) == 0) ? 0
                                                                     : $urandom_range(0, 255));
      case (p)
         0: c = '{watchdog_limit: 8'd1, off_level: 8'd0, min_override_level: 8'd0,
                  wake_level: 8'd0, max_step: 8'd1, passthrough_code: 8'd0};
         1: c = '{default: 8'hFF};
         2: begin
            c.watchdog_limit = 8'd255;
            c.max_step       = 8'd0;
         end
         // lowered below a watchdog that climbed in the phase before
         3: c.watchdog_limit = 8'd12;
         4: c.watchdog_limit = 8'd0;
         default: ;
      endcase
      return c;
   endfunction

   task automatic send_random(input dosc_cfg_type c, input int byte_pct, input int good_pct);
      logic [SAMPLE_BITS-1:0] smp;
      logic [LEVEL_BITS-1:0]  data;
      int                     roll;
      smp  = SAMPLE_BITS'($urandom_range(0, (1 << SAMPLE_BITS) - 1));
      data = LEVEL_BITS'($urandom_range(0, 255));
      if ($urandom_range(0, 99) < byte_pct) begin
         if ($urandom_range(0, 9) == 0) data = c.passthrough_code;
         send_word(OP_BYTE, smp, data, ($urandom_range(0, 99) < good_pct) ? ^data : ~^data);
      end else begin
         roll = $urandom_range(0, 99);
         if (roll < 12 && c.off_level != 0)
            smp[SAMPLE_BITS-1 -: LEVEL_BITS] = LEVEL_BITS'($urandom_range(0, c.off_level - 1));
         else if (roll < 22 && c.wake_level != 8'hFF)
            smp[SAMPLE_BITS-1 -: LEVEL_BITS] =
               LEVEL_BITS'($urandom_range(c.wake_level + 1, 255));
         send_word(OP_TICK, smp, data, 1'($urandom_range(0, 1)));
      end
   endtask

   initial begin : stimulus
      dosc_cfg_type plan;
      int           byte_pct;
      int           good_pct;
      reset               = 1'b1;
      psel                = 1'b0;
      penable             = 1'b0;
      pwrite              = 1'b0;
      paddr               = '0;
      pwdata              = '0;
      req_bus.valid       = 1'b0;
      req_bus.opcode      = OP_TICK;
      req_bus.dial_sample = '0;
      req_bus.rx_data     = '0;
      req_bus.rx_parity   = 1'b0;
      repeat (3) @(negedge clock);
      reset <= 1'b0;

      // directed words under the reset settings
      send_word(OP_TICK, 12'h000, 8'h00, 1'b0);
      send_word(OP_TICK, 12'hFFF, 8'hFF, 1'b1);
      send_word(OP_BYTE, 12'h000, 8'h64, ^8'h64);
      send_word(OP_TICK, 12'h800, 8'h00, 1'b0);
      send_word(OP_TICK, 12'h800, 8'h00, 1'b0);
      send_word(OP_BYTE, 12'hFFF, 8'h0A, ~^8'h0A);
      send_word(OP_TICK, 12'h800, 8'h00, 1'b0);
      send_word(OP_TICK, 12'h800, 8'h00, 1'b0);
      send_word(OP_BYTE, 12'h000, 8'h00, ^8'h00);
      send_word(OP_TICK, 12'h3FF, 8'h00, 1'b0);
      send_word(OP_BYTE, 12'h000, 8'hFF, ^8'hFF);
      send_word(OP_TICK, 12'hFFF, 8'h00, 1'b0);
      send_word(OP_TICK, 12'h04F, 8'h00, 1'b0);
      send_word(OP_TICK, 12'h050, 8'h00, 1'b0);
      send_word(OP_BYTE, 12'h000, 8'hAA, ^8'hAA);
      send_word(OP_TICK, 12'hE6F, 8'h00, 1'b0);
      send_word(OP_TICK, 12'hE70, 8'h00, 1'b0);
      send_word(OP_BYTE, 12'h000, 8'h55, ~^8'h55);
      send_word(OP_TICK, 12'h5A5, 8'h00, 1'b0);
      send_word(OP_BYTE, 12'h000, 8'h01, ^8'h01);
      send_word(OP_TICK, 12'h7FF, 8'h00, 1'b0);
      send_word(OP_TICK, 12'hA5A, 8'h00, 1'b0);

      for (int p = 0; p < PHASES; p++) begin
         drain(SETTLE_CYCLES);
         plan = plan_for(p);
         csr_program(plan);
         byte_pct = (p == 2 || p == 3) ? 3 : (p == 0) ? 30 : $urandom_range(5, 40);
         good_pct = (p == 3) ? 40 : 85;
         src_calm = (p == 1 || p == 6);
         rsp_calm = (p == 1 || p == 6);
         for (int i = 0; i < PHASE_WORDS; i++) begin
            if (i == 30 && (p == 5 || p == 9)) rsp_stall_req = 1'b1;
            if (i == 50 && p == 7) drain(0);
            // let the watchdog climb before the limit is lowered
            if (p == 2 && i >= 60) byte_pct = 0;
            send_random(plan, byte_pct, good_pct);
         end
      end

      drain(SETTLE_CYCLES);
      if (fail_count == 0 && words_due == 0) begin
         $display("tb_top OK");
      end else begin
         $display("tb_top NOT OK");
      end
      $finish;
   end

endmodule

`default_nettype wire
